// File: design/jsu_pkg.sv
// Shared types and constants for the JSON string unescape decoder.
`default_nettype none
package jsu_pkg;

   typedef enum logic [2:0] {
      PH_QUOTE = 3'd0,
      PH_TEXT  = 3'd1,
      PH_ESC   = 3'd2,
      PH_HEX   = 3'd3,
      PH_DONE  = 3'd4
   } phase_type;

   typedef enum logic [3:0] {
      ST_BUSY     = 4'd0,
      ST_DONE     = 4'd1,
      ST_NO_QUOTE = 4'd2,
      ST_END_ESC  = 4'd3,
      ST_SHORT_U  = 4'd4,
      ST_BAD_HEX  = 4'd5,
      ST_ABOVE    = 4'd6,
      ST_BAD_ESC  = 4'd7,
      ST_RAW_CTRL = 4'd8,
      ST_UNTERM   = 4'd9
   } status_type;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH     = 8'h2f;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_LOWER_N   = 8'h6e;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_U   = 8'h75;
   localparam logic [7:0] CTRL_LIMIT   = 8'h20;
   localparam logic [15:0] ASCII_MAX   = 16'h007f;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] hex_count;
      logic [15:0] code_value;
      logic       bad_hex_seen;
      status_type final_status;
   } dec_state_type;

   localparam dec_state_type DEC_RESET = '{
      phase:        PH_QUOTE,
      hex_count:    2'd0,
      code_value:   16'd0,
      bad_hex_seen: 1'b0,
      final_status: ST_BUSY
   };

   typedef struct packed {
      logic       char_valid;
      logic [7:0] decoded_char;
      status_type status;
      logic       finished;
   } dec_result_type;

endpackage
`default_nettype wire

// File: design/jsu_step.sv
// Per-byte decode: next decoder state and result from current state and one input byte.
`default_nettype none
module jsu_step
   import jsu_pkg::*;
(
   input  wire dec_state_type state,
   input  wire logic [7:0]    text_byte,
   input  wire logic          start_flag,
   input  wire logic          end_flag,
   output dec_state_type      state_next,
   output dec_result_type     result
);

   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      // bit 4 set = valid digit
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, 4'(b - 8'h30)};
      else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
      else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
      return r;
   endfunction

   dec_state_type cur;
   dec_state_type nxt;
   logic          valid;
   logic [7:0]    ch;
   logic [4:0]    nib;
   logic [15:0]   code_shift;

   assign cur        = start_flag ? DEC_RESET : state;
   assign nib        = hex_nibble(text_byte);
   assign code_shift = {cur.code_value[11:0], nib[3:0]};

   always_comb begin
      nxt   = cur;
      valid = 1'b0;
      ch    = 8'd0;
      unique case (cur.phase)
         PH_QUOTE: begin
            if (text_byte != CH_QUOTE) begin
               nxt.phase = PH_DONE; nxt.final_status = ST_NO_QUOTE;
            end else if (end_flag) begin
               nxt.phase = PH_DONE; nxt.final_status = ST_UNTERM;
            end else begin
               nxt.phase = PH_TEXT;
            end
         end
         PH_TEXT: begin
            if (text_byte == CH_QUOTE) begin
               nxt.phase = PH_DONE; nxt.final_status = ST_DONE;
            end else if (text_byte == CH_BACKSLASH) begin
               if (end_flag) begin
                  nxt.phase = PH_DONE; nxt.final_status = ST_END_ESC;
               end else begin
                  nxt.phase = PH_ESC;
               end
            end else if (text_byte < CTRL_LIMIT) begin
               nxt.phase = PH_DONE; nxt.final_status = ST_RAW_CTRL;
            end else begin
               valid = 1'b1;
               ch    = text_byte;
               if (end_flag) begin
                  nxt.phase = PH_DONE; nxt.final_status = ST_UNTERM;
               end
            end
         end
         PH_ESC: begin
            case (text_byte)
               CH_QUOTE, CH_BACKSLASH, CH_SLASH: begin
                  valid = 1'b1; ch = text_byte;
               end
               CH_LOWER_B: begin valid = 1'b1; ch = 8'h08; end
               CH_LOWER_F: begin valid = 1'b1; ch = 8'h0c; end
               CH_LOWER_N: begin valid = 1'b1; ch = 8'h0a; end
               CH_LOWER_R: begin valid = 1'b1; ch = 8'h0d; end
               CH_LOWER_T: begin valid = 1'b1; ch = 8'h09; end
               CH_LOWER_U: begin
                  if (end_flag) begin
                     nxt.phase = PH_DONE; nxt.final_status = ST_SHORT_U;
                  end else begin
                     nxt.phase        = PH_HEX;
                     nxt.hex_count    = 2'd0;
                     nxt.code_value   = 16'd0;
                     nxt.bad_hex_seen = 1'b0;
                  end
               end
               default: begin
                  nxt.phase = PH_DONE; nxt.final_status = ST_BAD_ESC;
               end
            endcase
            if (valid) begin
               if (end_flag) begin
                  nxt.phase = PH_DONE; nxt.final_status = ST_UNTERM;
               end else begin
                  nxt.phase = PH_TEXT;
               end
            end
         end
         PH_HEX: begin
            nxt.bad_hex_seen = cur.bad_hex_seen | ~nib[4];
            nxt.code_value   = code_shift;
            if (cur.hex_count != 2'd3) begin
               nxt.hex_count = cur.hex_count + 2'd1;
               // short input wins over an earlier bad digit
               if (end_flag) begin
                  nxt.phase = PH_DONE; nxt.final_status = ST_SHORT_U;
               end
            end else begin
               nxt.hex_count = 2'd0;
               if (nxt.bad_hex_seen) begin
                  nxt.phase = PH_DONE; nxt.final_status = ST_BAD_HEX;
               end else if (code_shift > ASCII_MAX) begin
                  nxt.phase = PH_DONE; nxt.final_status = ST_ABOVE;
               end else begin
                  valid = 1'b1;
                  ch    = code_shift[7:0];
                  if (end_flag) begin
                     nxt.phase = PH_DONE; nxt.final_status = ST_UNTERM;
                  end else begin
                     nxt.phase = PH_TEXT;
                  end
               end
            end
         end
         default: begin
            nxt.phase = PH_DONE;
         end
      endcase
   end

   always_comb begin
      state_next          = nxt;
      result.char_valid   = valid;
      result.decoded_char = ch;
      result.finished     = (nxt.phase == PH_DONE);
      result.status       = (nxt.phase == PH_DONE) ? nxt.final_status : ST_BUSY;
   end

endmodule
`default_nettype wire

// File: design/json_string_unescape_decoder.sv
// A result beat is registered into the head entry, or into the skid entry if the head is held.
// One byte per cycle while req_tready is high; the decoder state register updates on each accepted beat.
// A two-entry output buffer lets a request beat be taken while one result waits.
// Reset (synchronous, active high) puts the decoder in await-opening-quote and empties
// the output buffer; start_flag on a beat restarts decoding from that byte.
`default_nettype none
module json_string_unescape_decoder
   import jsu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   input  wire logic        req_tuser,   // [0] start_flag
   input  wire logic        req_tlast,   // end_flag
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,   // [7:0] decoded_char, [11:8] status, [15:12] zero
   output      logic        rsp_tuser,   // [0] char_valid
   output      logic        rsp_tlast    // finished
);

   dec_state_type  state_ff, state_in;
   dec_result_type step_result;
   dec_result_type head_ff, head_in;
   dec_result_type skid_ff, skid_in;
   logic           head_valid_ff, head_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   logic           push, pop;

   jsu_step u_step (
      .state      (state_ff),
      .text_byte  (req_tdata),
      .start_flag (req_tuser),
      .end_flag   (req_tlast),
      .state_next (state_in),
      .result     (step_result)
   );

   assign req_tready = ~skid_valid_ff;
   assign push       = req_tvalid & req_tready;
   assign pop        = head_valid_ff & rsp_tready;

   always_comb begin
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!head_valid_ff || pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            head_valid_in = 1'b1;
            skid_in       = step_result;
            skid_valid_in = push;
         end else begin
            head_in       = step_result;
            head_valid_in = push;
         end
      end else if (push) begin
         skid_in       = step_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= DEC_RESET;
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (push) begin
            state_ff <= state_in;
         end
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = head_valid_ff;
   assign rsp_tdata  = {4'd0, head_ff.status, head_ff.decoded_char};
   assign rsp_tuser  = head_ff.char_valid;
   assign rsp_tlast  = head_ff.finished;

`ifndef SYNTHESIS
   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry held without a head entry");

   a_done_has_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_DONE) == (state_ff.final_status != ST_BUSY))
      else $error("finished phase and final status disagree");

   a_finished_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (head_ff.status != ST_BUSY)))
      else $error("finished flag and status disagree on result beat");

   a_char_only_busy_or_unterm: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (head_ff.status == ST_BUSY || head_ff.status == ST_UNTERM))
      else $error("decoded byte beat carries a failure status");

   a_state_moves_on_push: assert property (@(posedge clock) disable iff (reset)
      !push |=> $stable(state_ff))
      else $error("decoder state changed without an accepted beat");
`endif

endmodule
`default_nettype wire
